// ----- sv/wmad_pkg.sv -----
// Shared types and constants for the windowed motion activity detector.
// Used by the front end, back end and top level; depends on nothing.
`default_nettype none

package wmad_pkg;

	localparam int ACCEL_W    = 12;
	localparam int DIFF_W     = ACCEL_W + 1;
	localparam int D2_W       = 2 * DIFF_W;
	localparam int P_W        = 2 * D2_W;
	localparam int SUM_W      = 64;
	localparam int THR_W      = 56;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;
	localparam int MQ_DEPTH   = 2;
	localparam int OUT_DEPTH  = 4;

	localparam logic REG_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		STATUS_INCOMPLETE = 2'd0,
		STATUS_INACTIVE   = 2'd1,
		STATUS_ACTIVE     = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
		logic                     add_en;
		logic                     close;
	} diff_t;

endpackage

`default_nettype wire

// ----- sv/windowed_motion_activity_detector_core.sv -----
// Windowed motion activity detector. Takes one three-axis accelerometer
// sample per transfer and returns one status per sample: incomplete for every
// sample but the last of a window of WINDOW_FRAMES samples, and at the last
// one inactive when the floor of the mean of the squared squared-distances
// between consecutive samples is below the threshold register, else active; the
// window state is then cleared. The front end takes a sample every clock while
// its two-entry difference queue has room; the back end squaring pipeline
// runs one item per clock, so the sustained rate is one sample per clock,
// bounded by the four-entry result queue when results are not popped. A
// sample's status passes through the difference queue, the squaring pipeline
// registers and the result queue. The threshold register sits at byte address
// 0 of the 64-bit configuration port. No clearing pass.
// Depends on wmad_pkg, wmad_fifo, wmad_front, wmad_back.
`default_nettype none

module windowed_motion_activity_detector_core #(
	parameter int WINDOW_FRAMES = 400,
	parameter int SAMPLE_BITS   = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [wmad_pkg::ACCEL_W-1:0]    accel_x,
	input  logic signed [wmad_pkg::ACCEL_W-1:0]    accel_y,
	input  logic signed [wmad_pkg::ACCEL_W-1:0]    accel_z,
	output logic                                   empty,
	input  logic                                   pop,
	output wmad_pkg::status_t                      activity_status,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [wmad_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [wmad_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [wmad_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                   pready
);

	import wmad_pkg::*;

	logic [THR_W-1:0]          threshold_q;
	logic                      reg_hit;
	logic                      mq_full;
	logic                      mq_push;
	diff_t                     mq_wdata;
	logic [$bits(diff_t)-1:0]  mq_rdata;
	logic                      mq_empty;
	logic                      mq_pop;
	logic [$clog2(MQ_DEPTH+1)-1:0] mq_count;
	diff_t                     mq_head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_THRESHOLD);
	assign prdata  = reg_hit ? CFG_DATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	wmad_front #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.WINDOW_FRAMES(WINDOW_FRAMES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.mq_full(mq_full),
		.mq_push(mq_push),
		.mq_data(mq_wdata)
	);

	wmad_fifo #(
		.WIDTH($bits(diff_t)),
		.DEPTH(MQ_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mq_push),
		.wdata (mq_wdata),
		.full  (mq_full),
		.pop   (mq_pop),
		.rdata (mq_rdata),
		.empty (mq_empty),
		.count (mq_count)
	);

	assign mq_head = diff_t'(mq_rdata);

	wmad_back #(
		.WINDOW_FRAMES(WINDOW_FRAMES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.threshold      (threshold_q),
		.mq_empty       (mq_empty),
		.mq_data        (mq_head),
		.mq_pop         (mq_pop),
		.pop            (pop),
		.empty          (empty),
		.activity_status(activity_status)
	);

	a_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		mq_empty == (mq_count == '0))
		else $error("difference queue count disagrees with empty flag");

	a_mid_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		mq_push |-> !mq_full)
		else $error("difference pushed into full queue");

	a_first_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		(mq_push && mq_wdata.close) |-> mq_wdata.add_en)
		else $error("window closed on its first sample");

endmodule

`default_nettype wire

// ----- sv/wmad_fifo.sv -----
// Small synchronous FIFO in flip-flops with an occupancy count.
// Generic; depends on nothing. DEPTH must be a power of two, at least 2.
`default_nettype none

module wmad_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- sv/wmad_front.sv -----
// Front end: accepts samples, tracks the window position and previous sample,
// and queues the axis differences. Depends on wmad_pkg.
`default_nettype none

module wmad_front #(
	parameter int SAMPLE_BITS   = 12,
	parameter int WINDOW_FRAMES = 400
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [wmad_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [wmad_pkg::ACCEL_W-1:0] accel_y,
	input  logic signed [wmad_pkg::ACCEL_W-1:0] accel_z,
	input  logic                                mq_full,
	output logic                                mq_push,
	output wmad_pkg::diff_t                     mq_data
);

	import wmad_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_FRAMES);
	localparam int EXT_W = DIFF_W - SAMPLE_BITS;

	logic [SAMPLE_BITS-1:0]   prev_x_q;
	logic [SAMPLE_BITS-1:0]   prev_y_q;
	logic [SAMPLE_BITS-1:0]   prev_z_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [DIFF_W-1:0] cur_x;
	logic signed [DIFF_W-1:0] cur_y;
	logic signed [DIFF_W-1:0] cur_z;
	logic signed [DIFF_W-1:0] old_x;
	logic signed [DIFF_W-1:0] old_y;
	logic signed [DIFF_W-1:0] old_z;
	logic                     last;

	assign full    = mq_full;
	assign mq_push = push & ~mq_full;
	assign last    = (count_q == CNT_W'(WINDOW_FRAMES - 1));

	always_comb begin
		cur_x = {{EXT_W{accel_x[SAMPLE_BITS-1]}}, accel_x[SAMPLE_BITS-1:0]};
		cur_y = {{EXT_W{accel_y[SAMPLE_BITS-1]}}, accel_y[SAMPLE_BITS-1:0]};
		cur_z = {{EXT_W{accel_z[SAMPLE_BITS-1]}}, accel_z[SAMPLE_BITS-1:0]};
		old_x = {{EXT_W{prev_x_q[SAMPLE_BITS-1]}}, prev_x_q};
		old_y = {{EXT_W{prev_y_q[SAMPLE_BITS-1]}}, prev_y_q};
		old_z = {{EXT_W{prev_z_q[SAMPLE_BITS-1]}}, prev_z_q};
		mq_data.dx     = cur_x - old_x;
		mq_data.dy     = cur_y - old_y;
		mq_data.dz     = cur_z - old_z;
		mq_data.add_en = (count_q != '0);
		mq_data.close  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (mq_push) begin
			if (last) begin
				count_q  <= '0;
				prev_x_q <= '0;
				prev_y_q <= '0;
				prev_z_q <= '0;
			end else begin
				count_q  <= count_q + 1'b1;
				prev_x_q <= accel_x[SAMPLE_BITS-1:0];
				prev_y_q <= accel_y[SAMPLE_BITS-1:0];
				prev_z_q <= accel_z[SAMPLE_BITS-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/wmad_back.sv -----
// Back end: squares the differences, squares their sum, accumulates the
// window power and judges it at window close. Depends on wmad_pkg, wmad_fifo.
`default_nettype none

module wmad_back #(
	parameter int WINDOW_FRAMES = 400
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [wmad_pkg::THR_W-1:0]       threshold,
	input  logic                             mq_empty,
	input  wmad_pkg::diff_t                  mq_data,
	output logic                             mq_pop,
	input  logic                             pop,
	output logic                             empty,
	output wmad_pkg::status_t                activity_status
);

	import wmad_pkg::*;

	localparam int CNT_W    = $clog2(WINDOW_FRAMES);
	localparam int SCALED_W = THR_W + CNT_W;
	localparam int CMP_W    = (SCALED_W > SUM_W) ? SCALED_W : SUM_W;
	localparam int OCNT_W   = $clog2(OUT_DEPTH + 1);
	localparam int CRD_W    = OCNT_W + 1;

	logic signed [D2_W-1:0] sq_x;
	logic signed [D2_W-1:0] sq_y;
	logic signed [D2_W-1:0] sq_z;
	logic [D2_W-1:0]        d2;
	logic                   issue;
	logic [OCNT_W-1:0]      out_count;
	logic                   out_full;
	logic [1:0]             out_rdata;

	logic                   v_s1;
	logic [D2_W-1:0]        d2_s1;
	logic                   add_s1;
	logic                   close_s1;
	logic                   v_s2;
	logic [P_W-1:0]         p_s2;
	logic                   add_s2;
	logic                   close_s2;

	logic [SUM_W-1:0]       sum_q;
	logic [SCALED_W-1:0]    scaled_q;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_next;
	logic                   inactive;
	status_t                status_next;

	always_comb begin
		sq_x  = D2_W'(mq_data.dx) * D2_W'(mq_data.dx);
		sq_y  = D2_W'(mq_data.dy) * D2_W'(mq_data.dy);
		sq_z  = D2_W'(mq_data.dz) * D2_W'(mq_data.dz);
		d2    = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
		issue = !mq_empty &&
			((CRD_W'(out_count) + CRD_W'(v_s1) + CRD_W'(v_s2)) < CRD_W'(OUT_DEPTH));
	end

	assign mq_pop = issue;

	always_comb begin
		sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(p_s2);
		sum_next = sum_q;
		if (add_s2) begin
			sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end
		inactive    = (CMP_W'(sum_next) < CMP_W'(scaled_q));
		status_next = STATUS_INCOMPLETE;
		if (close_s2) begin
			status_next = inactive ? STATUS_INACTIVE : STATUS_ACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			sum_q    <= '0;
			scaled_q <= '0;
		end else begin
			scaled_q <= SCALED_W'(threshold) * SCALED_W'(WINDOW_FRAMES - 1);
			v_s1     <= issue;
			v_s2     <= v_s1;
			if (v_s2) begin
				sum_q <= close_s2 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			d2_s1    <= d2;
			add_s1   <= mq_data.add_en;
			close_s1 <= mq_data.close;
		end
		if (v_s1) begin
			p_s2     <= P_W'(d2_s1) * P_W'(d2_s1);
			add_s2   <= add_s1;
			close_s2 <= close_s1;
		end
	end

	wmad_fifo #(
		.WIDTH(2),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (v_s2),
		.wdata (status_next),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty),
		.count (out_count)
	);

	assign activity_status = status_t'(out_rdata);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !out_full)
		else $error("result pushed into full queue");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CRD_W'(out_count) + CRD_W'(v_s1) + CRD_W'(v_s2)) <= CRD_W'(OUT_DEPTH))
		else $error("results in flight exceed queue room");

	a_clear_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && close_s2) |=> (sum_q == '0))
		else $error("power sum not cleared after window close");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> v_s1)
		else $error("issued item lost before first stage");

endmodule

`default_nettype wire
